[hdl/vct_pkg.sv]
// Shared types and constants of the vector clock table.
package vct_pkg;

    localparam int ID_W     = 64;
    localparam int CLOCK_W  = 64;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_MERGE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic search;
        logic update;
    } vct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } vct_stat_t;

endpackage

[hdl/vct_item_if.sv]
// Input channel carrying one tick or merge word.
interface vct_item_if import vct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [ID_W-1:0]    actor_key;
    logic [CLOCK_W-1:0] peer_clock;

    modport source (output valid, mode, actor_key, peer_clock, input ready);
    modport sink (input valid, mode, actor_key, peer_clock, output ready);
endinterface

[hdl/vct_result_if.sv]
// Output channel carrying one result word.
interface vct_result_if import vct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLOCK_W-1:0]  clock_value;

    modport source (output valid, status, clock_value, input ready);
    modport sink (input valid, status, clock_value, output ready);
endinterface

[hdl/vector_clock_table_unit.sv]
// Top level of the vector clock table: controller, datapath and assertions.
//
// This block keeps a vector clock as a table of CAPACITY (actor id, clock) pairs.
// A tick word (mode 0) adds one to the named actor's clock, wrapping at 2^64, and
// returns the new value; an unknown actor returns status not-found and clock zero.
// A merge word (mode 1) inserts a missing actor in the lowest free slot and then
// keeps the larger of the stored and incoming clocks; if the actor is missing and
// the table is full it returns status table-full and clock zero and changes
// nothing. Every accepted word gives exactly one result word. Slot zero always
// holds the own actor id; writing that register re-initializes the table to just
// that actor with clock zero, as reset does, and must only be done while the
// block is idle. Each word passes through a capture step, a search step for the
// parallel compare of the actor id against every slot together with the clock
// memory read, and an update step for the read-modify-write of the clock that
// also loads the result register. The input is taken only in the capture state,
// so a new word is not taken before the last one has left the update step,
// which waits while an earlier result still sits unread in the output register.
module vector_clock_table_unit import vct_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    vct_item_if.sink          item,
    vct_result_if.source      result,
    input  logic              cfg_wr_en,
    input  logic [ID_W-1:0]   cfg_wr_data
);

    vct_cmd_t  cmd;
    vct_stat_t stat;

    // The controller only sequences; all table state lives in the datapath.
    vct_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vct_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_mode         (item.mode),
        .in_actor_key    (item.actor_key),
        .in_peer_clock   (item.peer_clock),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_status      (result.status),
        .out_clock_value (result.clock_value)
    );

    // Once a word is taken, the block works on it alone until its result is made.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input taken while a word is still in work");

    // A word is accepted, searched, then updated: the input is still closed in the update state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> ##1 !item.ready)
        else $error("input reopened before the update cycle");

    // An error result always carries a zero clock.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != ST_OK)) |-> (result.clock_value == '0))
        else $error("error result with nonzero clock");

    // Only defined status codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status == ST_OK || result.status == ST_NOT_FOUND
                          || result.status == ST_TABLE_FULL))
        else $error("undefined status code");

endmodule

[hdl/vct_ctrl.sv]
// Controller state machine sequencing capture, search and update.
module vct_ctrl import vct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  vct_stat_t stat,
    output vct_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.search  = (state_reg == S_SEARCH);
    assign cmd.update  = (state_reg == S_UPDATE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/vct_datapath.sv]
// Table storage, actor search, clock update and result register.
module vct_datapath import vct_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  vct_cmd_t            cmd,
    output vct_stat_t           stat,
    input  logic                cfg_wr_en,
    input  logic [ID_W-1:0]     cfg_wr_data,
    input  logic                in_mode,
    input  logic [ID_W-1:0]     in_actor_key,
    input  logic [CLOCK_W-1:0]  in_peer_clock,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [CLOCK_W-1:0]  out_clock_value
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Captured input word.
    logic               mode_reg;
    logic [ID_W-1:0]    actor_reg;
    logic [CLOCK_W-1:0] theirs_reg;

    // Table. Slot zero always holds the own actor, whose id lives in own_id_reg.
    logic [ID_W-1:0]    own_id_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [ID_W-1:0]    actor_tab [CAPACITY];
    logic [CLOCK_W-1:0] clock_mem [CAPACITY];
    // Slot zero's clock reads as zero until it is first written after init.
    logic               zero0_reg;

    // Search results.
    logic [IDX_W-1:0]   slot_reg;
    logic               hit_reg;
    logic               free_reg;
    logic [CLOCK_W-1:0] rd_clock_reg;

    // Result register.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CLOCK_W-1:0]  out_clock_reg;

    logic [CAPACITY-1:0] match;
    logic [IDX_W-1:0]    hit_idx;
    logic [IDX_W-1:0]    free_idx;
    logic                any_hit;
    logic                any_free;
    logic [IDX_W-1:0]    slot_sel;

    logic [CLOCK_W-1:0]  cur_clock;
    logic [CLOCK_W-1:0]  new_clock;
    logic [STATUS_W-1:0] res_status;
    logic                wr_clock;
    logic                ins_entry;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                match[i] = valid_reg[i] && (own_id_reg == actor_reg);
            end
            else
            begin
                match[i] = valid_reg[i] && (actor_tab[i] == actor_reg);
            end
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit  = |match;
    assign any_free = ~&valid_reg;
    assign slot_sel = any_hit ? hit_idx : free_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= in_mode;
            actor_reg  <= in_actor_key;
            theirs_reg <= in_peer_clock;
        end
        if (cmd.search)
        begin
            slot_reg     <= slot_sel;
            hit_reg      <= any_hit;
            free_reg     <= any_free;
            rd_clock_reg <= clock_mem[slot_sel];
        end
    end

    assign cur_clock = (zero0_reg && (slot_reg == '0)) ? '0 : rd_clock_reg;

    always_comb
    begin
        new_clock  = '0;
        res_status = ST_OK;
        wr_clock   = 1'b0;
        ins_entry  = 1'b0;
        if (mode_reg == MODE_TICK)
        begin
            if (hit_reg)
            begin
                new_clock = cur_clock + CLOCK_W'(1);
                wr_clock  = 1'b1;
            end
            else
            begin
                res_status = ST_NOT_FOUND;
            end
        end
        else
        begin
            if (hit_reg)
            begin
                new_clock = (theirs_reg > cur_clock) ? theirs_reg : cur_clock;
                wr_clock  = 1'b1;
            end
            else if (free_reg)
            begin
                new_clock = theirs_reg;
                wr_clock  = 1'b1;
                ins_entry = 1'b1;
            end
            else
            begin
                res_status = ST_TABLE_FULL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && wr_clock)
        begin
            clock_mem[slot_reg] <= new_clock;
        end
        if (cmd.update && ins_entry)
        begin
            actor_tab[slot_reg] <= actor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            valid_reg  <= CAPACITY'(1);
            zero0_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            own_id_reg <= cfg_wr_data;
            valid_reg  <= CAPACITY'(1);
            zero0_reg  <= 1'b1;
        end
        else if (cmd.update)
        begin
            if (ins_entry)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (wr_clock && (slot_reg == '0))
            begin
                zero0_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_status_reg <= res_status;
            out_clock_reg  <= new_clock;
        end
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_clock_value = out_clock_reg;

endmodule

[sim/vector_clock_table_unit_tb.sv]
// Self-checking testbench of the vector clock table: directed words, then random phases.
module vector_clock_table_unit_tb import vct_pkg::*; ();

    // Table size of the block under test, and of the predictor's copy of the table.
    localparam int TABLE_SLOTS = 16;
    // Number of actor ids that random words mostly draw from. It is larger than the
    // table, so merges fill the table and later run into the table-full case.
    localparam int POOL_SIZE = 20;
    localparam int PHASE_WORDS = 110;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 80;
    // Cycles to let pass after the last result.
    localparam int SETTLE_CYCLES = 6;
    // Cycle count at which the watchdog ends a hung run.
    localparam int CYCLE_LIMIT = 200000;

    // One result word as the block should return it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLOCK_W-1:0]  clock_value;
    } clock_result_t;

    // One row of the directed stimulus. Where typed is set, the row carries the
    // result that must come back; other rows are checked against the predictor.
    typedef struct {
        logic               mode;
        logic [ID_W-1:0]    actor;
        logic [CLOCK_W-1:0] theirs;
        bit                 typed;
        clock_result_t      want;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [ID_W-1:0] cfg_wr_data;

    vct_item_if   item_ch ();
    vct_result_if result_ch ();

    vector_clock_table_unit #(
        .CAPACITY (TABLE_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predictor state: the own actor id and a private copy of the clock table.
    logic [ID_W-1:0]    own_id;
    bit                 slot_used  [TABLE_SLOTS];
    logic [ID_W-1:0]    slot_actor [TABLE_SLOTS];
    logic [CLOCK_W-1:0] slot_clock [TABLE_SLOTS];

    // Results that the block still owes, oldest first.
    clock_result_t clock_results_due [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    // Both sides skip their random idling while this is set.
    bit  steady_flow    = 0;
    // The stimulus sets this to ask the receiver for one long hold-off.
    bit  hold_pending   = 0;
    int  hold_left      = 0;

    directed_row_t directed_rows [$];
    logic [ID_W-1:0] actor_pool [POOL_SIZE];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Puts the predictor's table back to its initial form: only the own actor, at
    // clock zero, in slot zero. Reset and every write of the own id do this.
    function automatic void clear_clock_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_used[i]  = 0;
            slot_actor[i] = '0;
            slot_clock[i] = '0;
        end
        slot_used[0]  = 1;
        slot_actor[0] = own_id;
    endfunction

    // Applies one tick or merge word to the predictor's table and returns the
    // result word that the block must produce for it.
    function automatic clock_result_t advance_clock_table(input logic mode,
                                                          input logic [ID_W-1:0] actor,
                                                          input logic [CLOCK_W-1:0] theirs);
        clock_result_t res;
        int hit;
        int spare;
        hit   = -1;
        spare = -1;
        // The lowest matching slot wins; likewise the lowest free slot takes an insert.
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_actor[i] == actor)
                hit = i;
            if (!slot_used[i])
                spare = i;
        end
        res.status      = ST_OK;
        res.clock_value = '0;
        if (mode == MODE_TICK)
        begin
            if (hit < 0)
                res.status = ST_NOT_FOUND;
            else
            begin
                // The clock wraps from all ones back to zero.
                slot_clock[hit] = slot_clock[hit] + 1'b1;
                res.clock_value = slot_clock[hit];
            end
            return res;
        end
        if (hit < 0)
        begin
            if (spare < 0)
            begin
                // Missing actor and no room: nothing changes.
                res.status = ST_TABLE_FULL;
                return res;
            end
            hit = spare;
            slot_used[hit]  = 1;
            slot_actor[hit] = actor;
            slot_clock[hit] = '0;
        end
        if (theirs > slot_clock[hit])
            slot_clock[hit] = theirs;
        res.clock_value = slot_clock[hit];
        return res;
    endfunction

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    // Offers one word and returns at the edge where the block takes it. The
    // expected result is queued at that same edge, so the order of the queue is the
    // order in which the block accepted the words.
    task automatic send_word(input logic mode, input logic [ID_W-1:0] actor,
                             input logic [CLOCK_W-1:0] theirs,
                             input bit typed = 0, input clock_result_t want = '0);
        clock_result_t predicted;
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= mode;
        item_ch.actor_key  <= actor;
        item_ch.peer_clock <= theirs;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = advance_clock_table(mode, actor, theirs);
        clock_results_due.push_back(typed ? want : predicted);
    endtask

    // Random idling of the sender: valid drops for a few cycles now and then.
    task automatic maybe_idle_sender();
        if (!steady_flow && $urandom_range(99) < 12)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // Stops offering and waits until every owed result has come back, then lets
    // the block finish whatever it was doing.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (clock_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes the own actor id. The block is idle here, so the table restarts at once.
    task automatic write_own_id(input logic [ID_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        own_id = value;
        clear_clock_table();
    endtask

    function automatic void add_row(input logic mode, input logic [ID_W-1:0] actor,
                                    input logic [CLOCK_W-1:0] theirs, input bit typed,
                                    input logic [STATUS_W-1:0] status,
                                    input logic [CLOCK_W-1:0] clock_value);
        directed_row_t row;
        row.mode              = mode;
        row.actor             = actor;
        row.theirs            = theirs;
        row.typed             = typed;
        row.want.status       = status;
        row.want.clock_value  = clock_value;
        directed_rows.push_back(row);
    endfunction

    // Builds the directed table. It runs straight after reset, so the own actor
    // is id zero at clock zero.
    function automatic void build_directed_rows();
        // Ticking the own actor after reset gives one.
        add_row(MODE_TICK,  64'd0, 64'd0, 1, ST_OK, 64'd1);
        // Ticking an unknown actor reports not-found with clock zero.
        add_row(MODE_TICK,  '1,    64'd0, 1, ST_NOT_FOUND, 64'd0);
        // A smaller incoming clock leaves the stored one in place.
        add_row(MODE_MERGE, 64'd0, 64'd0, 0, ST_OK, 64'd0);
        // The largest incoming clock is taken as it is.
        add_row(MODE_MERGE, 64'd0, '1,    1, ST_OK, '1);
        // Ticking the largest clock wraps to zero.
        add_row(MODE_TICK,  64'd0, 64'd0, 1, ST_OK, 64'd0);
        // A new actor is inserted at zero, then follows the larger clock.
        add_row(MODE_MERGE, '1,    64'd0, 0, ST_OK, 64'd0);
        add_row(MODE_MERGE, '1,    64'd5, 0, ST_OK, 64'd0);
        add_row(MODE_MERGE, '1,    64'd3, 0, ST_OK, 64'd0);
        // Fill the remaining fourteen slots.
        for (int i = 1; i <= TABLE_SLOTS - 2; i++)
            add_row(MODE_MERGE, 64'h5A5A_0000_0000_0000 | ID_W'(i), random_word64(), 0,
                    ST_OK, 64'd0);
        // With the table full a new actor is refused, and a tick of it misses.
        add_row(MODE_MERGE, 64'h8000_0000_0000_0000, 64'd7, 1, ST_TABLE_FULL, 64'd0);
        add_row(MODE_TICK,  64'h8000_0000_0000_0000, 64'd0, 1, ST_NOT_FOUND, 64'd0);
        // A known actor still merges and ticks in a full table.
        add_row(MODE_MERGE, '1,    '1,    0, ST_OK, 64'd0);
        add_row(MODE_TICK,  '1,    64'd0, 0, ST_OK, 64'd0);
    endfunction

    // Incoming clocks: most often small, often close to the top so ticks wrap,
    // sometimes anything at all.
    function automatic logic [CLOCK_W-1:0] pick_their_clock();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return CLOCK_W'($urandom_range(40));
        if (r < 70)
            return '1 - CLOCK_W'($urandom_range(3));
        return random_word64();
    endfunction

    // One random phase: settle, write a new own id, then send random words.
    // Phase 0 forces a long receiver hold-off, phase 1 pauses the sender until
    // everything has come back, and the last phase runs with no idling at all.
    task automatic run_random_phase(input int phase, input logic [ID_W-1:0] new_id);
        logic [ID_W-1:0] actor;
        drain_results();
        write_own_id(new_id);
        // The pool holds the own actor, the id extremes and random ids.
        actor_pool[0] = new_id;
        actor_pool[1] = '0;
        actor_pool[2] = '1;
        actor_pool[3] = 64'h8000_0000_0000_0000;
        for (int i = 4; i < POOL_SIZE; i++)
            actor_pool[i] = random_word64();
        steady_flow = (phase == 3);
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            if (phase == 0 && n == 20)
                hold_pending = 1;
            if (phase == 1 && n == 55)
            begin
                item_ch.valid <= 1'b0;
                while (clock_results_due.size() != 0)
                    @(posedge clk);
            end
            else
                maybe_idle_sender();
            // A tenth of the words name a fresh random actor; those mostly miss.
            if ($urandom_range(99) < 10)
                actor = random_word64();
            else
                actor = actor_pool[$urandom_range(POOL_SIZE - 1)];
            send_word($urandom_range(1) ? MODE_MERGE : MODE_TICK, actor, pick_their_clock());
        end
    endtask

    // Receiver and checker. Each accepted result word is compared with the oldest
    // expectation; then ready for the next edge is chosen: held low during reset and
    // the long hold-off, otherwise low about 12 times in a hundred but never in steady flow.
    always @(posedge clk)
    begin : result_side
        clock_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (clock_results_due.size() == 0)
                report_mismatch($sformatf("unexpected word, status %0d clock %h",
                                          result_ch.status, result_ch.clock_value));
            else
            begin
                want = clock_results_due.pop_front();
                if (result_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_ch.status, want.status));
                if (result_ch.clock_value !== want.clock_value)
                    report_mismatch($sformatf("clock %h, expected %h",
                                              result_ch.clock_value, want.clock_value));
            end
        end
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_pending)
        begin
            hold_pending = 0;
            hold_left    = HOLD_CYCLES - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= steady_flow || ($urandom_range(99) >= 12);
    end

    // Main sequence: reset, the directed table, four random phases, the end.
    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_TICK;
        item_ch.actor_key   = '0;
        item_ch.peer_clock  = '0;
        result_ch.ready     = 1'b0;
        own_id              = '0;
        clear_clock_table();
        build_directed_rows();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            maybe_idle_sender();
            send_word(directed_rows[i].mode, directed_rows[i].actor,
                      directed_rows[i].theirs, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        run_random_phase(0, '1);
        run_random_phase(1, random_word64());
        run_random_phase(2, 64'h8000_0000_0000_0001);
        run_random_phase(3, '0);

        // Wait for the last results, then a few more cycles for anything stray.
        drain_results();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
hdl/vct_pkg.sv
hdl/vct_item_if.sv
hdl/vct_result_if.sv
hdl/vct_ctrl.sv
hdl/vct_datapath.sv
hdl/vector_clock_table_unit.sv
sim/vector_clock_table_unit_tb.sv
